[design/atl_pkg.sv]
package atl_pkg;

    localparam int CoordWidth   = 16;
    localparam int AngleWidth   = 16;
    localparam int RomWidth     = 14;
    localparam int NumWidth     = 17;
    localparam int DefTableSize = 4096;
    localparam int AnglePi      = 25736;
    localparam int AngleHalfPi  = 12868;
    localparam int CordicSteps  = 31;

    localparam longint CordicAngles [CordicSteps] = '{
        843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1
    };

    typedef logic signed [CoordWidth-1:0] coord_t;
    typedef logic signed [AngleWidth-1:0] angle_t;

    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic x_neg;
        logic y_neg;
        logic swap;
    } side_t;

    // atan((2*idx - size) / size) in Q13, vectoring rotation in Q30
    function automatic logic signed [RomWidth-1:0] atan_entry(
        input longint idx,
        input longint size
    );
        longint vx;
        longint vy;
        longint z;
        longint sx;
        longint sy;
        int     k;
        vx = size <<< 30;
        vy = (2 * idx - size) <<< 30;
        z  = 0;
        for (k = 0; k < CordicSteps; k++)
        begin
            sx = vx >>> k;
            sy = vy >>> k;
            if (vy >= 0)
            begin
                vx = vx + sy;
                vy = vy - sx;
                z  = z + CordicAngles[k];
            end
            else
            begin
                vx = vx - sy;
                vy = vy + sx;
                z  = z - CordicAngles[k];
            end
        end
        return RomWidth'((z + (longint'(1) <<< 16)) >>> 17);
    endfunction

endpackage

[design/atl_in_if.sv]
interface atl_in_if;
    import atl_pkg::*;

    logic   valid;
    logic   ready;
    coord_t coord_y;
    coord_t coord_x;

    modport source (output valid, coord_y, coord_x, input ready);
    modport sink (input valid, coord_y, coord_x, output ready);
endinterface

[design/atl_out_if.sv]
interface atl_out_if;
    import atl_pkg::*;

    logic   valid;
    logic   ready;
    angle_t angle;

    modport source (output valid, angle, input ready);
    modport sink (input valid, angle, output ready);
endinterface

[design/atl_prep.sv]
module atl_prep #(
    parameter int TABLE_SIZE = atl_pkg::DefTableSize,
    parameter int PROD_W     = atl_pkg::NumWidth + $clog2(atl_pkg::DefTableSize + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    atl_in_if.sink                      coord,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output logic [PROD_W-1:0]           dn_rem,
    output logic [atl_pkg::NumWidth-1:0] dn_div,
    output atl_pkg::side_t              dn_side
);
    import atl_pkg::*;

    logic                       a_valid_reg;
    logic                       a_ready;
    logic [NumWidth-1:0]        n_reg;
    logic [NumWidth-1:0]        d_reg;
    side_t                      side_a_reg;
    logic                       b_valid_reg;
    logic                       b_ready;
    logic [PROD_W-1:0]          rem_reg;
    logic [NumWidth-1:0]        div_reg;
    side_t                      side_b_reg;

    logic signed [NumWidth-1:0] x_ext;
    logic signed [NumWidth-1:0] y_ext;
    logic signed [NumWidth-1:0] ax;
    logic signed [NumWidth-1:0] ay;
    logic signed [NumWidth-1:0] den_mag;
    logic signed [NumWidth-1:0] num_sel;
    logic signed [NumWidth-1:0] num_adj;
    logic                       den_neg;
    side_t                      side_next;
    logic [NumWidth-1:0]        n_next;
    logic [NumWidth-1:0]        d_next;
    logic [PROD_W-1:0]          rem_next;

    always_comb
    begin
        x_ext            = NumWidth'(coord.coord_x);
        y_ext            = NumWidth'(coord.coord_y);
        side_next.x_zero = (coord.coord_x == '0);
        side_next.y_zero = (coord.coord_y == '0);
        side_next.x_neg  = coord.coord_x[CoordWidth-1];
        side_next.y_neg  = coord.coord_y[CoordWidth-1];
        ax               = side_next.x_neg ? -x_ext : x_ext;
        ay               = side_next.y_neg ? -y_ext : y_ext;
        side_next.swap   = (ax < ay);
        den_mag          = side_next.swap ? ay : ax;
        den_neg          = side_next.swap ? side_next.y_neg : side_next.x_neg;
        num_sel          = side_next.swap ? x_ext : y_ext;
        num_adj          = den_neg ? -num_sel : num_sel;
        n_next           = NumWidth'(num_adj + den_mag);
        d_next           = {den_mag[NumWidth-2:0], 1'b0};
    end

    assign rem_next = PROD_W'(n_reg) * PROD_W'(TABLE_SIZE);

    assign b_ready     = ~b_valid_reg | dn_ready;
    assign a_ready     = ~a_valid_reg | b_ready;
    assign coord.ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= coord.valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coord.valid && a_ready)
        begin
            n_reg      <= n_next;
            d_reg      <= d_next;
            side_a_reg <= side_next;
        end
        if (a_valid_reg && b_ready)
        begin
            rem_reg    <= rem_next;
            div_reg    <= d_reg;
            side_b_reg <= side_a_reg;
        end
    end

    assign dn_valid = b_valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_div   = div_reg;
    assign dn_side  = side_b_reg;

endmodule

[design/atl_div_cell.sv]
module atl_div_cell #(
    parameter int PROD_W  = atl_pkg::NumWidth + $clog2(atl_pkg::DefTableSize + 1),
    parameter int IDX_W   = $clog2(atl_pkg::DefTableSize + 1),
    parameter int BIT_POS = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  logic [PROD_W-1:0]            up_rem,
    input  logic [atl_pkg::NumWidth-1:0] up_div,
    input  logic [IDX_W-1:0]             up_quo,
    input  atl_pkg::side_t               up_side,
    output logic                         dn_valid,
    input  logic                         dn_ready,
    output logic [PROD_W-1:0]            dn_rem,
    output logic [atl_pkg::NumWidth-1:0] dn_div,
    output logic [IDX_W-1:0]             dn_quo,
    output atl_pkg::side_t               dn_side
);
    import atl_pkg::*;

    logic                valid_reg;
    logic [PROD_W-1:0]   rem_reg;
    logic [NumWidth-1:0] div_reg;
    logic [IDX_W-1:0]    quo_reg;
    side_t               side_reg;

    logic [PROD_W-1:0]   shifted;
    logic                fits;
    logic [PROD_W-1:0]   rem_next;
    logic [IDX_W-1:0]    quo_next;

    always_comb
    begin
        shifted           = PROD_W'(up_div) << BIT_POS;
        fits              = (up_rem >= shifted);
        rem_next          = fits ? (up_rem - shifted) : up_rem;
        quo_next          = up_quo;
        quo_next[BIT_POS] = fits;
    end

    assign up_ready = ~valid_reg | dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            rem_reg  <= rem_next;
            div_reg  <= up_div;
            quo_reg  <= quo_next;
            side_reg <= up_side;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_div   = div_reg;
    assign dn_quo   = quo_reg;
    assign dn_side  = side_reg;

`ifndef SYNTHESIS
    a_rem_below_step: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && div_reg != '0) |-> (rem_reg < (PROD_W'(div_reg) << BIT_POS)))
        else $error("remainder not reduced below shifted divisor");
`endif

endmodule

[design/atl_post.sv]
module atl_post #(
    parameter int TABLE_SIZE = atl_pkg::DefTableSize,
    parameter int IDX_W      = $clog2(atl_pkg::DefTableSize + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  logic [IDX_W-1:0] up_quo,
    input  atl_pkg::side_t   up_side,
    atl_out_if.source        result
);
    import atl_pkg::*;

    localparam int RetW = 18;

    logic signed [RomWidth-1:0] rom_mem [0:TABLE_SIZE];

    for (genvar e = 0; e <= TABLE_SIZE; e++)
    begin : g_rom
        localparam logic signed [RomWidth-1:0] Entry =
            atan_entry(longint'(e), longint'(TABLE_SIZE));
        assign rom_mem[e] = Entry;
    end

    logic                       a_valid_reg;
    logic                       a_ready;
    logic signed [RomWidth-1:0] rom_q_reg;
    side_t                      side_a_reg;
    logic                       b_valid_reg;
    logic                       b_ready;
    angle_t                     angle_reg;

    logic [IDX_W-1:0]           idx_clamp;
    logic signed [RetW-1:0]     base;
    logic signed [RetW-1:0]     fold;
    logic signed [RetW-1:0]     turn;
    logic signed [RetW-1:0]     sat;
    angle_t                     angle_next;

    assign idx_clamp = (up_quo > IDX_W'(TABLE_SIZE)) ? IDX_W'(TABLE_SIZE) : up_quo;

    always_comb
    begin
        base = RetW'(rom_q_reg);
        if (side_a_reg.swap)
        begin
            if (side_a_reg.x_neg == side_a_reg.y_neg)
                fold = RetW'(AngleHalfPi) - base;
            else
                fold = -RetW'(AngleHalfPi) - base;
        end
        else
            fold = base;
        if (side_a_reg.x_neg)
            turn = side_a_reg.y_neg ? (fold - RetW'(AnglePi)) : (fold + RetW'(AnglePi));
        else
            turn = fold;
        if (turn > RetW'(AnglePi))
            sat = RetW'(AnglePi);
        else if (turn < -RetW'(AnglePi))
            sat = -RetW'(AnglePi);
        else
            sat = turn;
        if (side_a_reg.x_zero)
        begin
            if (side_a_reg.y_neg)
                angle_next = AngleWidth'(-AngleHalfPi);
            else if (side_a_reg.y_zero)
                angle_next = '0;
            else
                angle_next = AngleWidth'(AngleHalfPi);
        end
        else if (side_a_reg.y_zero)
            angle_next = side_a_reg.x_neg ? AngleWidth'(AnglePi) : '0;
        else
            angle_next = AngleWidth'(sat);
    end

    assign b_ready  = ~b_valid_reg | result.ready;
    assign a_ready  = ~a_valid_reg | b_ready;
    assign up_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= up_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && a_ready)
        begin
            rom_q_reg  <= rom_mem[idx_clamp];
            side_a_reg <= up_side;
        end
        if (a_valid_reg && b_ready)
            angle_reg <= angle_next;
    end

    assign result.valid = b_valid_reg;
    assign result.angle = angle_reg;

`ifndef SYNTHESIS
    a_index_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (up_valid && !up_side.x_zero && !up_side.y_zero) |-> (up_quo <= IDX_W'(TABLE_SIZE)))
        else $error("table index beyond last entry");
`endif

endmodule

[design/atan2_table_lookup.sv]
// Channel   Dir   Payload                      Transfer
// coord     in    coord_y[15:0], coord_x[15:0] coord.valid & coord.ready
// result    out   angle[15:0]                  result.valid & result.ready
//
// One transfer per cycle in and out while result.ready stays high. The chain holds IDX_W =
// clog2(TABLE_SIZE+1) quotient-bit cells, one per index bit, between the
// prep stages and the ROM and angle stages of the post block.
// Reset clears the valid flags of every stage; the arctangent ROM is constant.
// A stalled result holds its stage; earlier stages keep filling empty slots.
module atan2_table_lookup #(
    parameter int TABLE_SIZE = atl_pkg::DefTableSize
) (
    input  logic      clk,
    input  logic      rst_n,
    atl_in_if.sink    coord,
    atl_out_if.source result
);
    import atl_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_SIZE + 1);
    localparam int PROD_W = NumWidth + IDX_W;

    logic                chain_valid [0:IDX_W];
    logic                chain_ready [0:IDX_W];
    logic [PROD_W-1:0]   chain_rem   [0:IDX_W];
    logic [NumWidth-1:0] chain_div   [0:IDX_W];
    logic [IDX_W-1:0]    chain_quo   [0:IDX_W];
    side_t               chain_side  [0:IDX_W];

    atl_prep #(
        .TABLE_SIZE (TABLE_SIZE),
        .PROD_W     (PROD_W)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .coord    (coord),
        .dn_valid (chain_valid[0]),
        .dn_ready (chain_ready[0]),
        .dn_rem   (chain_rem[0]),
        .dn_div   (chain_div[0]),
        .dn_side  (chain_side[0])
    );

    assign chain_quo[0] = '0;

    for (genvar i = 0; i < IDX_W; i++)
    begin : g_cell
        atl_div_cell #(
            .PROD_W  (PROD_W),
            .IDX_W   (IDX_W),
            .BIT_POS (IDX_W - 1 - i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up_rem   (chain_rem[i]),
            .up_div   (chain_div[i]),
            .up_quo   (chain_quo[i]),
            .up_side  (chain_side[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn_rem   (chain_rem[i+1]),
            .dn_div   (chain_div[i+1]),
            .dn_quo   (chain_quo[i+1]),
            .dn_side  (chain_side[i+1])
        );
    end

    atl_post #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chain_valid[IDX_W]),
        .up_ready (chain_ready[IDX_W]),
        .up_quo   (chain_quo[IDX_W]),
        .up_side  (chain_side[IDX_W]),
        .result   (result)
    );

`ifndef SYNTHESIS
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ($signed(result.angle) <= AnglePi
                          && $signed(result.angle) >= -AnglePi))
        else $error("angle outside plus or minus pi");

    a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> coord.ready)
        else $error("input refused while result stage is empty");

    a_ready_propagates: assert property (@(posedge clk) disable iff (!rst_n)
        result.ready |-> coord.ready)
        else $error("input refused while result side takes transfers");
`endif

endmodule
